### rtl/core/oais_pkg.sv
// ----------------------------------------------------------------------------
// oais_pkg
// Shared types and codes for the ordered array store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oais_pkg;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 9;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_RM_FRONT  = 3'd3,
    OP_RM_END    = 3'd4,
    OP_RM_POS    = 3'd5,
    OP_FIND      = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_INS,
    KIND_RM,
    KIND_FIND
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_DRAIN,
    S_COMMIT,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic check;
    logic step;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic err;
    logic walk;
    logic last;
  } dp_sts_t;

endpackage

### rtl/core/oais_ctrl.sv
// ----------------------------------------------------------------------------
// oais_ctrl
// Sequencer: check, walk the memory, drain the last access, commit, report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oais_ctrl
  import oais_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy,
  output logic    res_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.err) state_nxt = S_RESULT;
        else if (sts.walk) state_nxt = S_WALK;
        else state_nxt = S_COMMIT;
      end
      S_WALK: begin
        if (sts.last) state_nxt = S_DRAIN;
      end
      S_DRAIN:  state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_RESULT;
      S_RESULT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    res_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      S_CHECK:  cmd.check = 1'b1;
      S_WALK:   cmd.step = 1'b1;
      S_DRAIN:  ;
      S_COMMIT: cmd.commit = 1'b1;
      S_RESULT: res_valid = 1'b1;
      default:  ;
    endcase
  end

endmodule

### rtl/core/oais_dp.sv
// ----------------------------------------------------------------------------
// oais_dp
// Datapath: entry memory, count, request registers and the shift/scan engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oais_dp
  import oais_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [POS_W-1:0]    in_position,
  output dp_sts_t             sts,
  output logic [STATUS_W-1:0] res_status,
  output logic                res_found,
  output logic [COUNT_W-1:0]  res_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [VALUE_W-1:0] mem [DEPTH];

  logic [OP_W-1:0]    op_r;
  logic [VALUE_W-1:0] value_r;
  logic [POS_W-1:0]   pos_r;
  logic [CW-1:0]      count_r;
  logic [AW-1:0]      idx_r;
  logic [AW-1:0]      rd_addr_r;
  logic               rd_valid_r;
  logic [VALUE_W-1:0] rdata_r;
  logic               found_r;
  status_t            status_r;

  kind_t              kind;
  logic [PW-1:0]      cnt_x;
  logic [PW-1:0]      at;
  status_t            status_c;
  logic               walk_c;
  logic [AW-1:0]      idx_init;
  logic [AW-1:0]      end_idx;
  logic [AW-1:0]      at_idx;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [VALUE_W-1:0] mem_wd;

  assign cnt_x = PW'(count_r);

  // operation decode: kind and target position
  always_comb begin
    kind = KIND_NONE;
    at   = '0;
    case (op_r)
      OP_INS_FRONT: kind = KIND_INS;
      OP_INS_END: begin
        kind = KIND_INS;
        at   = cnt_x;
      end
      OP_INS_POS: begin
        kind = KIND_INS;
        at   = PW'(pos_r);
      end
      OP_RM_FRONT: kind = KIND_RM;
      OP_RM_END: begin
        kind = KIND_RM;
        at   = cnt_x - PW'(1);
      end
      OP_RM_POS: begin
        kind = KIND_RM;
        at   = PW'(pos_r);
      end
      OP_FIND: kind = KIND_FIND;
      default: kind = KIND_NONE;
    endcase
  end

  assign at_idx  = at[AW-1:0];
  assign end_idx = AW'(cnt_x - PW'(1));

  always_comb begin
    status_c = ST_OK;
    walk_c   = 1'b0;
    idx_init = '0;
    case (kind)
      KIND_INS: begin
        if (cnt_x == PW'(DEPTH)) status_c = ST_FULL;
        else if (at > cnt_x) status_c = ST_RANGE;
        walk_c   = (at < cnt_x);
        idx_init = end_idx;
      end
      KIND_RM: begin
        if (count_r == '0) status_c = ST_EMPTY;
        else if (at >= cnt_x) status_c = ST_RANGE;
        walk_c   = ((at + PW'(1)) < cnt_x);
        idx_init = AW'(at + PW'(1));
      end
      KIND_FIND: walk_c = (count_r != '0);
      default: ;
    endcase
  end

  assign sts.err  = (status_c != ST_OK);
  assign sts.walk = walk_c;
  assign sts.last = (kind == KIND_INS) ? (idx_r == at_idx) : (idx_r == end_idx);

  // pending shift write from the read issued last cycle, or the final put
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rdata_r;
    if (rd_valid_r && kind == KIND_INS) begin
      mem_we = 1'b1;
      mem_wa = rd_addr_r + AW'(1);
    end else if (rd_valid_r && kind == KIND_RM) begin
      mem_we = 1'b1;
      mem_wa = rd_addr_r - AW'(1);
    end else if (cmd.commit && kind == KIND_INS) begin
      mem_we = 1'b1;
      mem_wa = at_idx;
      mem_wd = value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.step) begin
      rdata_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_operation;
      value_r <= in_value;
      pos_r   <= in_position;
    end
    if (cmd.check) begin
      status_r <= status_c;
      idx_r    <= idx_init;
    end else if (cmd.step) begin
      idx_r <= (kind == KIND_INS) ? idx_r - AW'(1) : idx_r + AW'(1);
    end
    if (cmd.step) begin
      rd_addr_r <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      rd_valid_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      rd_valid_r <= cmd.step;
      if (cmd.latch) begin
        found_r <= 1'b0;
      end else if (rd_valid_r && kind == KIND_FIND && rdata_r == value_r) begin
        found_r <= 1'b1;
      end
      if (cmd.commit && kind == KIND_INS) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.commit && kind == KIND_RM) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  assign res_status = status_r;
  assign res_found  = found_r;
  assign res_count  = cnt_x[COUNT_W-1:0];

endmodule

### rtl/core/ordered_array_insert_remove_search.sv
// ----------------------------------------------------------------------------
// ordered_array_insert_remove_search
// Ordered array of unsigned 32-bit words with insert, remove and find requests.
// ----------------------------------------------------------------------------
// sequence: accept, check, walk, drain, commit, result; the walk covers the entries shifted
// or scanned and is skipped, with the drain, when nothing moves; an error goes from check to result
// busy drops the cycle after out_valid; a new request is taken only while busy is low
// during the walk a memory read and the write of the previous read can share a cycle
// reset: synchronous, clears the count; memory contents are not cleared
// out_valid is a one-cycle strobe, the receiver cannot stall
`timescale 1ns / 1ps

module ordered_array_insert_remove_search
  import oais_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [POS_W-1:0]    in_position,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_found,
  output logic [COUNT_W-1:0]  out_count
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  oais_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .res_valid (out_valid)
  );

  oais_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_operation (in_operation),
    .in_value     (in_value),
    .in_position  (in_position),
    .sts          (sts),
    .res_status   (out_status),
    .res_found    (out_found),
    .res_count    (out_count)
  );

endmodule
